[hdl/msn_pkg.sv]
// Shared types, constants and helpers for the move-stop-sense navigator.
// Used by msn_cordic and move_stop_sense_navigator_core.
`default_nettype none

package msn_pkg;

  typedef enum logic [2:0] {
    PH_SETTLE = 3'd0,
    PH_THINK  = 3'd1,
    PH_SCAN   = 3'd2,
    PH_MOVE   = 3'd3,
    PH_ARRIVE = 3'd4,
    PH_STUCK  = 3'd5
  } phase_t;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_DECODE,
    SQ_DIST_X, SQ_DIST_Y, SQ_DIST_R, SQ_DIST_EVAL,
    SQ_CORR, SQ_WGT, SQ_BLEND_G, SQ_BLEND_C, SQ_REL,
    SQ_CORDIC_GO, SQ_CORDIC_WAIT,
    SQ_PROJ_E, SQ_PROJ_N, SQ_PROJ_DONE,
    SQ_SPD_A, SQ_SPD_B, SQ_SPD_DONE,
    SQ_OUT
  } seq_t;

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_POS  = 2'd1;
  localparam logic [1:0] SIDE_NEG  = 2'd2;

  localparam logic [2:0] REG_USE_MAP       = 3'd0;
  localparam logic [2:0] REG_FIELD_OF_VIEW = 3'd1;
  localparam logic [2:0] REG_OPEN_TO_MOVE  = 3'd2;
  localparam logic [2:0] REG_OPEN_TO_KEEP  = 3'd3;
  localparam logic [2:0] REG_STEP_LENGTH   = 3'd4;
  localparam logic [2:0] REG_ESCAPE_RADIUS = 3'd5;
  localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd6;
  localparam logic [2:0] REG_CRUISE_GAIN   = 3'd7;

  localparam int HALF_TURN = 11520;
  localparam int FULL_TURN = 23040;
  localparam int QUARTER   = 5760;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [31:0] CORDIC_K = 32'sd652032874;
  // 2^18 / 5, rounded up; exact for quotients below 43690
  localparam logic [31:0] RECIP_5 = 32'd52429;

  typedef struct packed {
    logic               start;
    logic signed [18:0] ang;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] sin_q30;
    logic signed [31:0] cos_q30;
  } cordic_rsp_t;

  // Wrap into [-11519, 11520]; inputs stay within three turns of that range.
  function automatic logic signed [14:0] wrap_half(input logic signed [18:0] d);
    logic signed [18:0] r;
    r = d;
    for (int i = 0; i < 3; i++) begin
      if (r > 19'(HALF_TURN)) r = r - 19'(FULL_TURN);
      else if (r < 19'(1 - HALF_TURN)) r = r + 19'(FULL_TURN);
    end
    return r[14:0];
  endfunction

  // atan(2^-i) in 1/16384 degree
  function automatic logic signed [23:0] atan_of(input logic [3:0] i);
    logic signed [23:0] v;
    case (i)
      4'd0:  v = 24'sd737280;
      4'd1:  v = 24'sd435242;
      4'd2:  v = 24'sd229970;
      4'd3:  v = 24'sd116736;
      4'd4:  v = 24'sd58595;
      4'd5:  v = 24'sd29326;
      4'd6:  v = 24'sd14667;
      4'd7:  v = 24'sd7334;
      4'd8:  v = 24'sd3667;
      4'd9:  v = 24'sd1833;
      4'd10: v = 24'sd917;
      4'd11: v = 24'sd458;
      4'd12: v = 24'sd229;
      4'd13: v = 24'sd115;
      4'd14: v = 24'sd57;
      default: v = 24'sd29;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/msn_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on nothing; operands are selected by the navigator sequencer.
`default_nettype none

module msn_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

[hdl/msn_cordic.sv]
// Iterative CORDIC sine/cosine in Q30, one rotation per cycle.
// Depends on msn_pkg (request/response structs, wrap_half, atan_of).
`default_nettype none

module msn_cordic import msn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  logic               run;
  logic               done;
  logic [3:0]         step;
  logic               neg;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [23:0] z;
  logic signed [14:0] a_w;
  logic signed [14:0] a_f;
  logic               neg_f;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [23:0] at;

  // fold into the right half plane; a folded angle's result is negated afterwards
  always_comb begin
    a_w = wrap_half(req.ang);
    a_f = a_w;
    neg_f = 1'b0;
    if (a_w > 15'(QUARTER)) begin
      a_f = a_w - 15'(HALF_TURN);
      neg_f = 1'b1;
    end else if (a_w < 15'(-QUARTER)) begin
      a_f = a_w + 15'(HALF_TURN);
      neg_f = 1'b1;
    end
  end

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = atan_of(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      run <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (run) begin
      step <= step + 4'd1;
      if (step == 4'(CORDIC_STEPS - 1)) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= CORDIC_K;
      y <= '0;
      z <= 24'(a_f) <<< 8;
      neg <= neg_f;
    end else if (run) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.sin_q30 = neg ? -y : y;
  assign rsp.cos_q30 = neg ? -x : x;

endmodule

`default_nettype wire

[hdl/move_stop_sense_navigator_core.sv]
// Move-stop-sense navigator: six-phase machine, one result item per item.
// Depends on msn_pkg, msn_mul (shared multiplier) and msn_cordic (sine/cosine).
`default_nettype none

// One input item produces one result item. Hover items (settle, think into scan,
// scan, stuck, restart) go straight from decode to the output step; an arrive,
// a scan timeout or a move that ends its leg runs the distance check through
// the shared multiplier; think into a leg goes through steering blend, a CORDIC
// pass and the waypoint products; a running move adds the distance check and
// the speed products. The single multiplier, used by one step at a time, and
// the CORDIC loop set the length of each path. The input side is ready only
// while the sequencer is idle, so the next item is taken only after the output
// step has loaded the result; a finished result waits in the output register
// while the next item is taken, and a result that cannot be loaded holds the
// sequencer. Configuration writes are accepted every cycle.
module move_stop_sense_navigator_core import msn_pkg::*; #(
  parameter int unsigned SETTLE_TIME_MS   = 1000,
  parameter int unsigned SETTLE_SPEED_CMS = 20,
  parameter int unsigned SCAN_TIMEOUT_MS  = 8000,
  parameter int unsigned MOVE_TIMEOUT_MS  = 5000
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tick_ms[15:0] ground_speed[31:16] open_fraction[42:32]
  // corridor_offset[54:43] heading[69:55] goal_heading[85:70]
  // route_heading[101:86] route_valid[102] pos_east[126:103]
  // pos_north[150:127], zero pad [151]
  input  logic [151:0] s_tdata,
  // kind[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // phase_code[2:0] speed_scale[13:3] bearing_cmd[29:14] yaw_sweep[30]
  // wp_east[54:31] wp_north[78:55], zero pad [79]
  output logic [79:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // configuration
  logic        use_map;
  logic [14:0] fov;
  logic [10:0] open_to_move;
  logic [10:0] open_to_keep;
  logic [15:0] step_length;
  logic [15:0] escape_radius;
  logic [7:0]  attempt_limit;
  logic [10:0] cruise_gain;

  // machine state
  seq_t               seq;
  seq_t               seq_next;
  phase_t             phase;
  logic [31:0]        timer;
  logic [1:0]         round_side;
  logic [1:0]         sweep_side;
  logic [7:0]         fail_tally;
  logic               anchor_set;
  logic signed [23:0] anchor_e;
  logic signed [23:0] anchor_n;
  logic signed [23:0] leg_e;
  logic signed [23:0] leg_n;
  logic signed [23:0] wp_e;
  logic signed [23:0] wp_n;

  // latched item
  logic               in_kind;
  logic [15:0]        in_dt;
  logic [15:0]        in_spd;
  logic [10:0]        in_open;
  logic signed [11:0] in_off;
  logic signed [14:0] in_hd;
  logic signed [15:0] in_goal;
  logic signed [15:0] in_route;
  logic               in_rv;
  logic signed [23:0] in_e;
  logic signed [23:0] in_n;

  // working registers
  logic               dist_tally;
  logic               mv_run;
  logic               quit;
  logic signed [18:0] bear;
  logic               sweep_w;
  logic [10:0]        speed;
  logic signed [16:0] corr;
  logic [10:0]        w;
  logic signed [50:0] acc;
  logic signed [18:0] desired;

  // output register
  logic [2:0]         o_phase;
  logic [10:0]        o_speed;
  logic signed [15:0] o_bear;
  logic               o_sweep;
  logic signed [23:0] o_we;
  logic signed [23:0] o_wn;

  // shared units
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] mul_p;
  cordic_req_t        creq;
  cordic_rsp_t        crsp;

  msn_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (mul_p)
  );

  msn_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // ---------------- combinational helpers ----------------
  logic               s_acc;
  logic [32:0]        tsum33;
  logic [31:0]        tsum;
  logic               settle_done;
  logic               think_go;
  logic               scan_tout;
  logic               move_quit;
  logic [13:0]        half;
  logic signed [15:0] g_sel;
  logic signed [14:0] rg_wrap;
  logic signed [14:0] half_s;
  logic signed [14:0] rel_goal;
  logic [11:0]        aoff;
  logic [10:0]        defl;
  logic [10:0]        one_m_defl;
  logic signed [14:0] r_route;
  logic [14:0]        r_route_abs;
  logic [1:0]         sweep_pick;
  logic [1:0]         side_now;
  logic               sweeping;
  logic [15:0]        aoff10;
  logic [14:0]        open10;
  logic [14:0]        os;
  logic [1:0]         rs_next;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic [15:0]        rad;
  logic               dist_far;
  logic               dist_ge;
  logic [7:0]         tally_inc;
  logic [10:0]        w_now;
  logic signed [50:0] blend_sum;
  logic signed [17:0] rel_raw;
  logic signed [17:0] rel;
  logic signed [18:0] desired_next;
  logic signed [15:0] bear_sat;
  logic               out_load;

  function automatic logic signed [23:0] proj(input logic signed [23:0] base,
                                              input logic signed [63:0] p);
    logic signed [63:0] sh;
    logic signed [25:0] s;
    sh = (p + 64'sd536870912) >>> 30;
    s = 26'(base) + 26'(sh);
    if (s > 26'sd8388607) return 24'sd8388607;
    if (s < -26'sd8388608) return -24'sd8388608;
    return s[23:0];
  endfunction

  assign s_acc = s_tvalid && s_tready;
  assign s_tready = (seq == SQ_IDLE);
  assign cfg_ready = 1'b1;

  assign tsum33 = {1'b0, timer} + 33'(in_dt);
  assign tsum = tsum33[32] ? 32'hFFFF_FFFF : tsum33[31:0];
  assign settle_done = (tsum >= 32'(SETTLE_TIME_MS)) && (32'(in_spd) < 32'(SETTLE_SPEED_CMS));
  assign think_go = (in_open >= open_to_move);
  assign scan_tout = (tsum >= 32'(SCAN_TIMEOUT_MS));
  assign move_quit = (tsum >= 32'(MOVE_TIMEOUT_MS)) || (in_open < open_to_keep);

  // goal (or route, when the map is used and valid) bearing relative to heading, clamped to half the view
  assign half = fov[14:1];
  assign half_s = $signed({1'b0, half});
  assign g_sel = (use_map && in_rv) ? in_route : in_goal;
  assign rg_wrap = wrap_half(19'(g_sel) - 19'(in_hd));
  always_comb begin
    if (rg_wrap > half_s) rel_goal = half_s;
    else if (rg_wrap < -half_s) rel_goal = -half_s;
    else rel_goal = rg_wrap;
  end

  assign aoff = in_off[11] ? (~in_off + 12'd1) : in_off;
  assign defl = (aoff > 12'd1024) ? 11'd1024 : aoff[10:0];
  assign one_m_defl = 11'd1024 - defl;

  // sweep side chosen on the first scan tick of an episode
  assign r_route = wrap_half(19'(in_route) - 19'(in_hd));
  assign r_route_abs = r_route[14] ? 15'(-r_route) : r_route;
  always_comb begin
    if (use_map && in_rv) begin
      if (r_route_abs < 15'd192) sweep_pick = (round_side != SIDE_NONE) ? round_side : SIDE_NEG;
      else sweep_pick = r_route[14] ? SIDE_NEG : SIDE_POS;
    end else begin
      if (round_side != SIDE_NONE) sweep_pick = round_side;
      else sweep_pick = ((18'(in_off) * 18'sd50) > 18'sd1024) ? SIDE_POS : SIDE_NEG;
    end
  end
  assign side_now = (sweep_side == SIDE_NONE) ? sweep_pick : sweep_side;
  assign sweeping = !in_kind && (phase == PH_SCAN) && !think_go && !scan_tout;

  assign aoff10 = 16'(aoff) * 16'd10;
  assign open10 = 15'(in_open) * 15'd10;
  assign os = (open10 < 15'd3072) ? 15'd3072 : ((open10 > 15'd10240) ? 15'd10240 : open10);
  always_comb begin
    if (aoff10 > 16'd3072) rs_next = in_off[11] ? SIDE_NEG : SIDE_POS;
    else if (open10 > 15'd6144 && aoff10 < 16'd1024) rs_next = SIDE_NONE;
    else rs_next = round_side;
  end

  assign dx = 25'(in_e) - 25'(dist_tally ? anchor_e : leg_e);
  assign dy = 25'(in_n) - 25'(dist_tally ? anchor_n : leg_n);
  assign rad = dist_tally ? escape_radius : step_length;
  assign dist_far = acc > 51'(mul_p);
  assign dist_ge = acc >= 51'(mul_p);
  assign tally_inc = (fail_tally == 8'hFF) ? fail_tally : fail_tally + 8'd1;

  assign w_now = 11'((mul_p + 64'sd512) >>> 10);
  assign blend_sum = acc + 51'(mul_p);
  assign rel_raw = 18'((blend_sum + 51'sd512) >>> 10);
  // pulled at least as far as a nonzero corridor
  always_comb begin
    rel = rel_raw;
    if (corr < 0 && 18'(corr) < rel_raw) rel = 18'(corr);
    if (corr > 0 && 18'(corr) > rel_raw) rel = 18'(corr);
  end
  assign desired_next = 19'(in_hd) + 19'(rel);

  assign bear_sat = (bear > 19'sd32767) ? 16'sd32767 :
                    ((bear < -19'sd32768) ? -16'sd32768 : bear[15:0]);
  assign out_load = (seq == SQ_OUT) && (!m_tvalid || m_tready);

  // ---------------- sequencer: next state ----------------
  always_comb begin
    seq_next = seq;
    case (seq)
      SQ_IDLE: if (s_acc) seq_next = SQ_DECODE;
      SQ_DECODE: begin
        if (in_kind) begin
          seq_next = SQ_OUT;
        end else begin
          case (phase)
            PH_THINK:  seq_next = think_go ? SQ_CORR : SQ_OUT;
            PH_SCAN:   seq_next = (!think_go && scan_tout) ? SQ_DIST_X : SQ_OUT;
            PH_MOVE:   seq_next = SQ_DIST_X;
            PH_ARRIVE: seq_next = SQ_DIST_X;
            default:   seq_next = SQ_OUT;
          endcase
        end
      end
      SQ_DIST_X: seq_next = SQ_DIST_Y;
      SQ_DIST_Y: seq_next = SQ_DIST_R;
      SQ_DIST_R: seq_next = SQ_DIST_EVAL;
      SQ_DIST_EVAL: seq_next = (dist_tally || dist_ge || quit) ? SQ_OUT : SQ_CORR;
      SQ_CORR: seq_next = SQ_WGT;
      SQ_WGT: seq_next = SQ_BLEND_G;
      SQ_BLEND_G: seq_next = SQ_BLEND_C;
      SQ_BLEND_C: seq_next = SQ_REL;
      SQ_REL: seq_next = SQ_CORDIC_GO;
      SQ_CORDIC_GO: seq_next = SQ_CORDIC_WAIT;
      SQ_CORDIC_WAIT: if (crsp.done) seq_next = SQ_PROJ_E;
      SQ_PROJ_E: seq_next = SQ_PROJ_N;
      SQ_PROJ_N: seq_next = SQ_PROJ_DONE;
      SQ_PROJ_DONE: seq_next = mv_run ? SQ_SPD_A : SQ_OUT;
      SQ_SPD_A: seq_next = SQ_SPD_B;
      SQ_SPD_B: seq_next = SQ_SPD_DONE;
      SQ_SPD_DONE: seq_next = SQ_OUT;
      SQ_OUT: if (out_load) seq_next = SQ_IDLE;
      default: seq_next = SQ_IDLE;
    endcase
  end

  // ---------------- sequencer: unit controls ----------------
  always_comb begin
    op_a = '0;
    op_b = '0;
    creq.start = 1'b0;
    creq.ang = desired;
    case (seq)
      SQ_DIST_X: begin op_a = 32'(dx); op_b = 32'(dx); end
      SQ_DIST_Y: begin op_a = 32'(dy); op_b = 32'(dy); end
      SQ_DIST_R: begin op_a = 32'(rad); op_b = 32'(rad); end
      SQ_CORR: begin op_a = 32'(in_off); op_b = 32'(half); end
      SQ_WGT: begin op_a = 32'(one_m_defl); op_b = 32'(one_m_defl); end
      SQ_BLEND_G: begin op_a = 32'(w_now); op_b = 32'(rel_goal); end
      SQ_BLEND_C: begin op_a = 32'(11'd1024 - w); op_b = 32'(corr); end
      SQ_CORDIC_GO: creq.start = 1'b1;
      SQ_PROJ_E: begin op_a = 32'(step_length); op_b = crsp.sin_q30; end
      SQ_PROJ_N: begin op_a = 32'(step_length); op_b = crsp.cos_q30; end
      SQ_SPD_A: begin op_a = 32'(cruise_gain); op_b = 32'(os); end
      SQ_SPD_B: begin op_a = 32'(mul_p[24:11]); op_b = RECIP_5; end
      default: ;
    endcase
  end

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      use_map <= 1'b1;
      fov <= 15'd5760;
      open_to_move <= 11'd512;
      open_to_keep <= 11'd307;
      step_length <= 16'd200;
      escape_radius <= 16'd100;
      attempt_limit <= 8'd3;
      cruise_gain <= 11'd716;
      seq <= SQ_IDLE;
      phase <= PH_SETTLE;
      timer <= '0;
      round_side <= SIDE_NONE;
      sweep_side <= SIDE_NONE;
      fail_tally <= '0;
      anchor_set <= 1'b0;
      anchor_e <= '0;
      anchor_n <= '0;
      leg_e <= '0;
      leg_n <= '0;
      wp_e <= '0;
      wp_n <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_USE_MAP:       use_map <= cfg_data[0];
          REG_FIELD_OF_VIEW: fov <= cfg_data[14:0];
          REG_OPEN_TO_MOVE:  open_to_move <= cfg_data[10:0];
          REG_OPEN_TO_KEEP:  open_to_keep <= cfg_data[10:0];
          REG_STEP_LENGTH:   step_length <= cfg_data;
          REG_ESCAPE_RADIUS: escape_radius <= cfg_data;
          REG_ATTEMPT_LIMIT: attempt_limit <= cfg_data[7:0];
          REG_CRUISE_GAIN:   cruise_gain <= cfg_data[10:0];
          default: ;
        endcase
      end

      seq <= seq_next;

      case (seq)
        SQ_DECODE: begin
          if (in_kind) begin
            phase <= PH_SETTLE;
            timer <= '0;
            round_side <= SIDE_NONE;
            sweep_side <= SIDE_NONE;
            fail_tally <= '0;
            anchor_set <= 1'b0;
          end else begin
            timer <= tsum;
            case (phase)
              PH_SETTLE: begin
                if (settle_done) begin
                  phase <= PH_THINK;
                  timer <= '0;
                end
              end
              PH_THINK: begin
                timer <= '0;
                if (think_go) begin
                  leg_e <= in_e;
                  leg_n <= in_n;
                  phase <= PH_MOVE;
                end else begin
                  phase <= PH_SCAN;
                  sweep_side <= SIDE_NONE;
                end
              end
              PH_SCAN: begin
                if (think_go) begin
                  phase <= PH_THINK;
                  timer <= '0;
                  sweep_side <= SIDE_NONE;
                end else if (scan_tout) begin
                  sweep_side <= SIDE_NONE;
                  timer <= '0;
                  if (!anchor_set) begin
                    anchor_e <= in_e;
                    anchor_n <= in_n;
                    anchor_set <= 1'b1;
                  end
                end else begin
                  sweep_side <= side_now;
                end
              end
              PH_ARRIVE: begin
                timer <= '0;
                if (!anchor_set) begin
                  anchor_e <= in_e;
                  anchor_n <= in_n;
                  anchor_set <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        SQ_DIST_EVAL: begin
          if (dist_tally) begin
            if (dist_far) begin
              anchor_e <= in_e;
              anchor_n <= in_n;
              fail_tally <= '0;
              phase <= PH_SETTLE;
            end else begin
              fail_tally <= tally_inc;
              phase <= (tally_inc >= attempt_limit) ? PH_STUCK : PH_SETTLE;
            end
          end else if (dist_ge || quit) begin
            phase <= PH_ARRIVE;
            timer <= '0;
          end else begin
            round_side <= rs_next;
          end
        end
        SQ_PROJ_N: wp_e <= proj(in_e, mul_p);
        SQ_PROJ_DONE: wp_n <= proj(in_n, mul_p);
        default: ;
      endcase

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (out_load) m_tvalid <= 1'b1;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_kind  <= s_tuser;
      in_dt    <= s_tdata[15:0];
      in_spd   <= s_tdata[31:16];
      in_open  <= s_tdata[42:32];
      in_off   <= $signed(s_tdata[54:43]);
      in_hd    <= $signed(s_tdata[69:55]);
      in_goal  <= $signed(s_tdata[85:70]);
      in_route <= $signed(s_tdata[101:86]);
      in_rv    <= s_tdata[102];
      in_e     <= $signed(s_tdata[126:103]);
      in_n     <= $signed(s_tdata[150:127]);
    end

    case (seq)
      SQ_DECODE: begin
        bear <= 19'(in_hd);
        speed <= '0;
        sweep_w <= 1'b0;
        mv_run <= 1'b0;
        quit <= move_quit;
        dist_tally <= (phase != PH_MOVE);
        if (sweeping) begin
          sweep_w <= 1'b1;
          bear <= (side_now == SIDE_POS) ? 19'(in_hd) + 19'(QUARTER)
                                         : 19'(in_hd) - 19'(QUARTER);
        end
      end
      SQ_DIST_Y: acc <= 51'(mul_p);
      SQ_DIST_R: acc <= acc + 51'(mul_p);
      SQ_DIST_EVAL: if (!dist_tally && !dist_ge && !quit) mv_run <= 1'b1;
      SQ_WGT: corr <= 17'((mul_p + 64'sd512) >>> 10);
      SQ_BLEND_G: w <= w_now;
      SQ_BLEND_C: acc <= 51'(mul_p);
      SQ_REL: begin
        desired <= desired_next;
        if (mv_run) bear <= desired_next;
      end
      SQ_SPD_DONE: speed <= (mul_p[31:18] > 14'd1024) ? 11'd1024 : mul_p[28:18];
      default: ;
    endcase

    if (out_load) begin
      o_phase <= phase;
      o_speed <= speed;
      o_bear  <= bear_sat;
      o_sweep <= sweep_w;
      o_we    <= wp_e;
      o_wn    <= wp_n;
    end
  end

  assign m_tdata = {1'b0, o_wn, o_we, o_sweep, o_bear, o_speed, o_phase};

  // ---------------- checks ----------------
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> seq == SQ_DECODE)
    else $error("accepted item not decoded");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(seq) == SQ_OUT)
    else $error("result raised outside output step");

  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_speed <= 11'd1024)
    else $error("speed above full scale");

  a_sweep_scan: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_sweep) |-> o_phase == PH_SCAN)
    else $error("sweep outside scan");

endmodule

`default_nettype wire

[dv/tb_move_stop_sense_navigator_core.sv]
// Testbench for move_stop_sense_navigator_core: directed and random ticks checked
// against a cycle-free predictor of the six-phase navigator.
// Depends on msn_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_move_stop_sense_navigator_core;
  import msn_pkg::*;

  typedef struct {
    bit     restart;
    longint dt, spd, open, off, hd, goal, route, e, n;
    bit     rvalid;
  } nav_tick_t;

  typedef struct {
    logic [2:0]  phase;
    logic [10:0] speed;
    logic [15:0] bearing;
    logic        sweep;
    logic [23:0] wpe, wpn;
  } nav_result_t;

  logic         clk = 0, rst = 1;
  logic         s_tvalid = 0, s_tready, s_tuser = 0;
  logic [151:0] s_tdata = '0;
  logic         m_tvalid, m_tready = 0;
  logic [79:0]  m_tdata;
  logic         cfg_valid = 0, cfg_ready;
  logic [2:0]   cfg_index = REG_USE_MAP;
  logic [15:0]  cfg_data = '0;

  move_stop_sense_navigator_core dut (.*);

  always #5 clk = ~clk;

  // register copies
  longint r_use_map, r_fov, r_open_move, r_open_keep, r_step, r_radius, r_limit, r_gain;
  // machine state copy
  phase_t nav_phase;
  longint nav_timer, round_side, sweep_side, fail_tally, anchor_e, anchor_n;
  longint leg_e, leg_n, wp_e, wp_n;
  bit     anchor_set;

  nav_result_t expected_results[$];
  int     errors = 0, items_sent = 0, results_seen = 0;
  int     phase_hits[8];
  bit     calm = 0;
  longint walk_e = 0, walk_n = 0;
  int     cycles = 0;

  localparam longint TIMER_MAX = 64'hFFFF_FFFF;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_turn(longint d);
    longint r;
    r = (d - (HALF_TURN + 1)) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r - (HALF_TURN - 1);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, z, xs, ys;
    bit flip;
    a = wrap_turn(ang);
    x = CORDIC_K;
    y = 0;
    flip = 0;
    if (a > QUARTER) begin
      a -= HALF_TURN; flip = 1;
    end else if (a < -QUARTER) begin
      a += HALF_TURN; flip = 1;
    end
    z = a * 256;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_of(4'(i)));
      end else begin
        x += ys; y -= xs; z += longint'(atan_of(4'(i)));
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint steer_bearing(nav_tick_t t);
    longint half, g, rel_goal, corr, defl, w, rel;
    half = r_fov >> 1;
    g = (r_use_map != 0 && t.rvalid) ? t.route : t.goal;
    rel_goal = clampl(wrap_turn(g - t.hd), -half, half);
    corr = (t.off * half + 512) >>> 10;
    defl = absl(t.off);
    if (defl > 1024) defl = 1024;
    w = ((1024 - defl) * (1024 - defl) + 512) >> 10;
    rel = (w * rel_goal + (1024 - w) * corr + 512) >>> 10;
    if (corr < 0 && corr < rel) rel = corr;
    if (corr > 0 && corr > rel) rel = corr;
    return t.hd + rel;
  endfunction

  function automatic void project_waypoint(longint e, longint n, longint ang);
    longint s, c;
    sin_cos(ang, s, c);
    wp_e = clampl(e + ((r_step * s + (64'sd1 << 29)) >>> 30), -8388608, 8388607);
    wp_n = clampl(n + ((r_step * c + (64'sd1 << 29)) >>> 30), -8388608, 8388607);
  endfunction

  function automatic bit attempt_stuck(longint e, longint n);
    longint dx, dy;
    if (!anchor_set) begin
      anchor_e = e; anchor_n = n; anchor_set = 1;
    end
    dx = e - anchor_e;
    dy = n - anchor_n;
    if (dx * dx + dy * dy > r_radius * r_radius) begin
      anchor_e = e; anchor_n = n; fail_tally = 0;
      return 0;
    end
    if (fail_tally < 255) fail_tally++;
    return fail_tally >= r_limit;
  endfunction

  function automatic void clear_nav();
    nav_phase = PH_SETTLE; nav_timer = 0; round_side = SIDE_NONE; sweep_side = SIDE_NONE;
    fail_tally = 0; anchor_set = 0;
  endfunction

  function automatic nav_result_t predict_tick(nav_tick_t t);
    nav_result_t res;
    longint bearing, speed, d, dx, dy, r, os, aoff;
    bit sweep;
    bearing = t.hd;
    speed = 0;
    sweep = 0;
    if (t.restart) begin
      clear_nav();
    end else begin
      nav_timer = nav_timer + t.dt;
      if (nav_timer > TIMER_MAX) nav_timer = TIMER_MAX;
      case (nav_phase)
        PH_SETTLE: begin
          if (nav_timer >= 1000 && t.spd < 20) begin
            nav_phase = PH_THINK; nav_timer = 0;
          end
        end
        PH_THINK: begin
          if (t.open >= r_open_move) begin
            d = steer_bearing(t);
            leg_e = t.e; leg_n = t.n;
            project_waypoint(t.e, t.n, d);
            nav_phase = PH_MOVE;
          end else begin
            nav_phase = PH_SCAN; sweep_side = SIDE_NONE;
          end
          nav_timer = 0;
        end
        PH_SCAN: begin
          if (t.open >= r_open_move) begin
            nav_phase = PH_THINK; nav_timer = 0; sweep_side = SIDE_NONE;
          end else if (nav_timer >= 8000) begin
            sweep_side = SIDE_NONE; nav_timer = 0;
            nav_phase = attempt_stuck(t.e, t.n) ? PH_STUCK : PH_SETTLE;
          end else begin
            if (sweep_side == SIDE_NONE) begin
              if (r_use_map != 0 && t.rvalid) begin
                r = wrap_turn(t.route - t.hd);
                if (absl(r) < 192) sweep_side = round_side != 0 ? round_side : SIDE_NEG;
                else sweep_side = r >= 0 ? SIDE_POS : SIDE_NEG;
              end else begin
                sweep_side = round_side != 0 ? round_side :
                             (t.off * 50 > 1024 ? SIDE_POS : SIDE_NEG);
              end
            end
            sweep = 1;
            bearing = t.hd + (sweep_side == SIDE_POS ? QUARTER : -QUARTER);
          end
        end
        PH_MOVE: begin
          dx = t.e - leg_e;
          dy = t.n - leg_n;
          if (dx * dx + dy * dy >= r_step * r_step || nav_timer >= 5000 ||
              t.open < r_open_keep) begin
            nav_phase = PH_ARRIVE; nav_timer = 0;
          end else begin
            d = steer_bearing(t);
            bearing = d;
            os = clampl(t.open * 10, 3072, 10240);
            speed = clampl(r_gain * os / 10240, 0, 1024);
            aoff = absl(t.off);
            if (aoff * 10 > 3072) round_side = t.off < 0 ? SIDE_NEG : SIDE_POS;
            else if (t.open * 10 > 6144 && aoff * 10 < 1024) round_side = SIDE_NONE;
            project_waypoint(t.e, t.n, d);
          end
        end
        PH_ARRIVE: begin
          nav_phase = attempt_stuck(t.e, t.n) ? PH_STUCK : PH_SETTLE;
          nav_timer = 0;
        end
        default: ;
      endcase
    end
    bearing = clampl(bearing, -32768, 32767);
    res.phase = nav_phase;
    res.speed = 11'(speed);
    res.bearing = 16'(bearing);
    res.sweep = sweep;
    res.wpe = 24'(wp_e);
    res.wpn = 24'(wp_n);
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 26);
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb_move_stop_sense_navigator_core failed");
      $finish;
    end
  end

  task automatic send_tick(nav_tick_t t);
    nav_result_t exp_res;
    s_tvalid <= 1;
    s_tuser <= t.restart;
    s_tdata <= {1'b0, 24'(t.n), 24'(t.e), t.rvalid, 16'(t.route), 16'(t.goal),
                15'(t.hd), 12'(t.off), 11'(t.open), 16'(t.spd), 16'(t.dt)};
    do @(posedge clk); while (!s_tready);
    exp_res = predict_tick(t);
    expected_results.push_back(exp_res);
    phase_hits[exp_res.phase]++;
    items_sent++;
    if (!calm && $urandom_range(99) < 26) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_USE_MAP:       r_use_map = value & 1;
      REG_FIELD_OF_VIEW: r_fov = value & 16'h7FFF;
      REG_OPEN_TO_MOVE:  r_open_move = value & 11'h7FF;
      REG_OPEN_TO_KEEP:  r_open_keep = value & 11'h7FF;
      REG_STEP_LENGTH:   r_step = value & 16'hFFFF;
      REG_ESCAPE_RADIUS: r_radius = value & 16'hFFFF;
      REG_ATTEMPT_LIMIT: r_limit = value & 8'hFF;
      default:           r_gain = value & 11'h7FF;
    endcase
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    nav_result_t e_res, a_res;
    if (!rst && m_tvalid && m_tready) begin
      a_res.phase = m_tdata[2:0];
      a_res.speed = m_tdata[13:3];
      a_res.bearing = m_tdata[29:14];
      a_res.sweep = m_tdata[30];
      a_res.wpe = m_tdata[54:31];
      a_res.wpn = m_tdata[78:55];
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e_res = expected_results.pop_front();
        if (a_res.phase !== e_res.phase) begin
          $error("phase_code exp %0d got %0d", e_res.phase, a_res.phase); errors++;
        end
        if (a_res.speed !== e_res.speed) begin
          $error("speed_scale exp %0d got %0d", e_res.speed, a_res.speed); errors++;
        end
        if (a_res.bearing !== e_res.bearing) begin
          $error("bearing_cmd exp %0d got %0d", $signed(e_res.bearing),
                 $signed(a_res.bearing)); errors++;
        end
        if (a_res.sweep !== e_res.sweep) begin
          $error("yaw_sweep exp %0d got %0d", e_res.sweep, a_res.sweep); errors++;
        end
        if (a_res.wpe !== e_res.wpe) begin
          $error("wp_east exp %0d got %0d", $signed(e_res.wpe), $signed(a_res.wpe));
          errors++;
        end
        if (a_res.wpn !== e_res.wpn) begin
          $error("wp_north exp %0d got %0d", $signed(e_res.wpn), $signed(a_res.wpn));
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic nav_tick_t base_tick();
    nav_tick_t t;
    t.restart = 0; t.dt = 100; t.spd = 0; t.open = 1024; t.off = 0; t.hd = 0;
    t.goal = 0; t.route = 0; t.rvalid = 0; t.e = walk_e; t.n = walk_n;
    return t;
  endfunction

  function automatic longint pick_signed(int bits, longint lo, longint hi);
    if ($urandom_range(99) < 15)
      return longint'($urandom_range((1 << bits) - 1)) - (64'sd1 << (bits - 1));
    return longint'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic nav_tick_t random_tick();
    nav_tick_t t;
    int mode;
    t = base_tick();
    mode = $urandom_range(99);
    t.restart = (mode < 3);
    case ($urandom_range(3))
      0: t.dt = $urandom_range(65535);
      1: t.dt = $urandom_range(1500, 4000);
      default: t.dt = $urandom_range(0, 600);
    endcase
    t.spd = $urandom_range(99) < 70 ? $urandom_range(0, 25) : $urandom_range(65535);
    t.open = $urandom_range(99) < 10 ? $urandom_range(2047) : $urandom_range(1024);
    t.off = pick_signed(12, -1024, 1024);
    t.hd = pick_signed(15, -11520, 11520);
    t.goal = pick_signed(16, -23040, 23040);
    t.route = pick_signed(16, -23040, 23040);
    if ($urandom_range(3) == 0) t.route = t.hd + $urandom_range(0, 400) - 200;
    t.rvalid = $urandom_range(1);
    // mostly a slow walk so legs end and anchors get revisited
    if ($urandom_range(99) < 8) begin
      walk_e = pick_signed(24, -8388608, 8388607);
      walk_n = pick_signed(24, -8388608, 8388607);
    end else begin
      walk_e = clampl(walk_e + $urandom_range(0, 160) - 80, -8388608, 8388607);
      walk_n = clampl(walk_n + $urandom_range(0, 160) - 80, -8388608, 8388607);
    end
    t.e = walk_e;
    t.n = walk_n;
    return t;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_tick(random_tick());
  endtask

  task automatic test_directed_defaults();
    nav_tick_t t;
    t = base_tick();
    send_tick(t);                       // settle, timer short
    t.restart = 1; send_tick(t);
    t = base_tick(); t.dt = 65535; t.spd = 65535; send_tick(t);   // too fast
    t.spd = 19; send_tick(t);           // settle -> think
    t = base_tick(); t.open = 1024; t.off = 1024; t.hd = 11520; t.goal = -23040;
    t.rvalid = 1; t.route = 23040; send_tick(t);                  // think -> move
    t.off = -1024; t.hd = -11520; t.dt = 0; t.open = 2047; send_tick(t);
    t.off = 2047; t.hd = 16383; t.goal = 32767; t.rvalid = 0; send_tick(t);
    t.off = -2048; t.hd = -16384; t.goal = -32768; send_tick(t);
    t = base_tick(); t.dt = 65535; send_tick(t);                  // move timeout
    send_tick(t);                                                 // arrive
    t.spd = 0; send_tick(t);                                      // settle -> think
    t = base_tick(); t.open = 0; send_tick(t);                    // think -> scan
    t.rvalid = 1; t.route = 100; t.dt = 0; send_tick(t);          // near route
    t = base_tick(); t.open = 0; t.dt = 65535; send_tick(t);      // scan timeout
    t.e = 8388607; t.n = -8388608; send_tick(t);
    t = base_tick(); t.open = 1024; send_tick(t);                 // think -> move
    t.e = walk_e + 300; send_tick(t);                             // leg length reached
    t.restart = 1; send_tick(t);
  endtask

  task automatic test_register_extremes();
    drain();
    write_reg(REG_USE_MAP, 0);
    write_reg(REG_FIELD_OF_VIEW, 64);
    write_reg(REG_OPEN_TO_MOVE, 0);
    write_reg(REG_OPEN_TO_KEEP, 0);
    write_reg(REG_STEP_LENGTH, 1);
    write_reg(REG_ESCAPE_RADIUS, 1);
    write_reg(REG_ATTEMPT_LIMIT, 1);
    write_reg(REG_CRUISE_GAIN, 0);
    run_random(120);
    drain();
    write_reg(REG_USE_MAP, 1);
    write_reg(REG_FIELD_OF_VIEW, 32767);
    write_reg(REG_OPEN_TO_MOVE, 1024);
    write_reg(REG_OPEN_TO_KEEP, 1024);
    write_reg(REG_STEP_LENGTH, 65535);
    write_reg(REG_ESCAPE_RADIUS, 65535);
    write_reg(REG_ATTEMPT_LIMIT, 255);
    write_reg(REG_CRUISE_GAIN, 2047);
    run_random(120);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(REG_USE_MAP, $urandom_range(1));
      write_reg(REG_FIELD_OF_VIEW, $urandom_range(64, 23040));
      write_reg(REG_OPEN_TO_MOVE, $urandom_range(0, 1024));
      write_reg(REG_OPEN_TO_KEEP, $urandom_range(0, 1024));
      write_reg(REG_STEP_LENGTH, $urandom_range(1, 400));
      write_reg(REG_ESCAPE_RADIUS, $urandom_range(1, 300));
      write_reg(REG_ATTEMPT_LIMIT, $urandom_range(1, 5));
      write_reg(REG_CRUISE_GAIN, $urandom_range(0, 1024));
      run_random(110);
    end
  endtask

  task automatic test_back_to_back();
    calm = 1;
    run_random(60);
    calm = 0;
    drain();                            // sender waits for every result
    run_random(40);
  endtask

  initial begin
    r_use_map = 1; r_fov = 5760; r_open_move = 512; r_open_keep = 307;
    r_step = 200; r_radius = 100; r_limit = 3; r_gain = 716;
    clear_nav();
    anchor_e = 0; anchor_n = 0; leg_e = 0; leg_n = 0; wp_e = 0; wp_n = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed_defaults();
    test_back_to_back();
    test_register_extremes();
    test_random_settings();
    drain();
    if (expected_results.size() != 0) errors++;
    $display("Ran %0d ticks (%0d results): settle %0d think %0d scan %0d move %0d",
             items_sent, results_seen, phase_hits[0], phase_hits[1], phase_hits[2],
             phase_hits[3]);
    $display("arrive %0d stuck %0d, over default, extreme and random register sets",
             phase_hits[4], phase_hits[5]);
    if (errors == 0) begin
      $display("tb_move_stop_sense_navigator_core passed");
    end else begin
      $display("tb_move_stop_sense_navigator_core failed");
    end
    $finish;
  end

endmodule
